/* rtl/core/bole_pkg.sv */
`default_nettype none

package bole_pkg;

  localparam int REQ_W  = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_AT    = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_BACK  = 3'd4,
    REQ_DEL_AT    = 3'd5,
    REQ_RD_FWD    = 3'd6,
    REQ_RD_BACK   = 3'd7
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic    load;
    logic    setup;
    logic    step_move;
    logic    step_emit;
    logic    put;
    logic    dec_occ;
    logic    resp;
    status_t resp_status;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic ins;
    logic full;
    logic empty;
    logic pos_bad;
    logic at_end;
    logic ptr_last;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/core/bole_ctrl.sv */
`default_nettype none

module bole_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire bole_pkg::dp_stat_t stat,
  output logic                    busy,
  output bole_pkg::dp_cmd_t       cmd
);

  import bole_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_FIN_DEL,
    S_READ
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.resp_status = ST_OK;
    state_nxt       = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.setup = 1'b1;
        unique case (stat.req) inside
          REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT: begin
            if (stat.full) begin
              cmd.resp        = 1'b1;
              cmd.resp_status = ST_FULL;
              state_nxt       = S_IDLE;
            end else if (stat.pos_bad) begin
              cmd.resp        = 1'b1;
              cmd.resp_status = ST_BAD_POS;
              state_nxt       = S_IDLE;
            end else if (stat.at_end) begin
              state_nxt = S_PUT;
            end else begin
              state_nxt = S_SHIFT;
            end
          end
          REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT: begin
            if (stat.empty) begin
              cmd.resp        = 1'b1;
              cmd.resp_status = ST_EMPTY;
              state_nxt       = S_IDLE;
            end else if (stat.pos_bad) begin
              cmd.resp        = 1'b1;
              cmd.resp_status = ST_BAD_POS;
              state_nxt       = S_IDLE;
            end else if (stat.at_end) begin
              state_nxt = S_FIN_DEL;
            end else begin
              state_nxt = S_SHIFT;
            end
          end
          default: begin
            if (stat.empty) begin
              cmd.resp        = 1'b1;
              cmd.resp_status = ST_EMPTY;
              state_nxt       = S_IDLE;
            end else begin
              state_nxt = S_READ;
            end
          end
        endcase
      end
      S_SHIFT: begin
        cmd.step_move = 1'b1;
        if (stat.ptr_last) begin
          state_nxt = stat.ins ? S_DRAIN : S_FIN_DEL;
        end
      end
      S_DRAIN: begin
        state_nxt = S_PUT;
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        cmd.resp  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_FIN_DEL: begin
        cmd.dec_occ = 1'b1;
        cmd.resp    = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_READ: begin
        cmd.step_emit = 1'b1;
        if (stat.ptr_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/bole_dp.sv */
`default_nettype none

module bole_dp #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire bole_pkg::dp_cmd_t                  cmd,
  input  wire logic [bole_pkg::REQ_W-1:0]         in_req_type,
  input  wire logic signed [bole_pkg::VAL_W-1:0]  in_value,
  input  wire logic [bole_pkg::POS_W-1:0]         in_position,
  output bole_pkg::dp_stat_t                      stat,
  output logic                                    out_valid,
  output logic [bole_pkg::STAT_W-1:0]             out_status,
  output logic signed [bole_pkg::VAL_W-1:0]       out_elem_value,
  output logic [$clog2(CAPACITY+1)-1:0]           out_count,
  output logic                                    out_last
);

  import bole_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  req_t                  req_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [DATA_WIDTH-1:0] val_c;
  logic [POS_W-1:0]      pos_r;

  logic [CNT_W-1:0]      occ_r;
  logic [CNT_W-1:0]      occ_nxt;
  logic [CNT_W-1:0]      occ_dec;
  logic [CMP_W-1:0]      occ_ext;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      ins_at_c;
  logic [CMP_W-1:0]      del_at_c;
  logic [CMP_W-1:0]      at_c;

  logic [ADDR_W-1:0]     occ_m1;
  logic [ADDR_W-1:0]     at_r;
  logic [ADDR_W-1:0]     ptr_r;
  logic [ADDR_W-1:0]     stop_r;
  logic [ADDR_W-1:0]     ptr_start;
  logic [ADDR_W-1:0]     ptr_stop;
  logic [ADDR_W-1:0]     mv_addr_r;
  logic [ADDR_W-1:0]     wr_addr;

  logic                  is_ins;
  logic                  is_del;
  logic                  dir_up;
  logic                  mv_vld_r;
  logic                  rd_en;
  logic                  wr_en;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [VAL_W-1:0]      rd_ext;

  logic                  out_vld_r;
  status_t               out_status_r;
  logic [CNT_W-1:0]      out_count_r;
  logic                  out_last_r;
  logic                  out_rd_r;

  generate
    if (DATA_WIDTH > VAL_W) begin : g_wide
      assign val_c  = {{(DATA_WIDTH-VAL_W){1'b0}}, in_value};
      assign rd_ext = rd_data_r[VAL_W-1:0];
    end else if (DATA_WIDTH == VAL_W) begin : g_same
      assign val_c  = in_value;
      assign rd_ext = rd_data_r;
    end else begin : g_narrow
      assign val_c  = in_value[DATA_WIDTH-1:0];
      assign rd_ext = {{(VAL_W-DATA_WIDTH){rd_data_r[DATA_WIDTH-1]}}, rd_data_r};
    end
  endgenerate

  assign occ_ext = CMP_W'(occ_r);
  assign pos_ext = CMP_W'(pos_r);
  assign occ_dec = occ_r - CNT_W'(1);
  assign occ_m1  = occ_dec[ADDR_W-1:0];

  assign is_ins = (req_r == REQ_INS_FRONT) || (req_r == REQ_INS_BACK) ||
                  (req_r == REQ_INS_AT);
  assign is_del = (req_r == REQ_DEL_FRONT) || (req_r == REQ_DEL_BACK) ||
                  (req_r == REQ_DEL_AT);
  assign dir_up = is_del || (req_r == REQ_RD_FWD);

  always_comb begin
    case (req_r)
      REQ_INS_FRONT: ins_at_c = '0;
      REQ_INS_BACK:  ins_at_c = occ_ext;
      default:       ins_at_c = pos_ext;
    endcase
    case (req_r)
      REQ_DEL_FRONT: del_at_c = '0;
      REQ_DEL_BACK:  del_at_c = occ_ext - CMP_W'(1);
      default:       del_at_c = pos_ext;
    endcase
  end

  assign at_c = is_ins ? ins_at_c : del_at_c;

  always_comb begin
    case (req_r) inside
      REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT: begin
        ptr_start = occ_m1;
        ptr_stop  = at_c[ADDR_W-1:0];
      end
      REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT: begin
        ptr_start = at_c[ADDR_W-1:0] + ADDR_W'(1);
        ptr_stop  = occ_m1;
      end
      REQ_RD_FWD: begin
        ptr_start = '0;
        ptr_stop  = occ_m1;
      end
      default: begin
        ptr_start = occ_m1;
        ptr_stop  = '0;
      end
    endcase
  end

  assign stat.req      = req_r;
  assign stat.ins      = is_ins;
  assign stat.full     = (occ_r == CNT_W'(CAPACITY));
  assign stat.empty    = (occ_r == '0);
  assign stat.pos_bad  = is_ins ? (ins_at_c > occ_ext) : (del_at_c >= occ_ext);
  assign stat.at_end   = is_ins ? (ins_at_c == occ_ext) :
                                  (del_at_c == (occ_ext - CMP_W'(1)));
  assign stat.ptr_last = (ptr_r == stop_r);

  always_comb begin
    if (cmd.put) begin
      occ_nxt = occ_r + CNT_W'(1);
    end else if (cmd.dec_occ) begin
      occ_nxt = occ_dec;
    end else begin
      occ_nxt = occ_r;
    end
  end

  assign rd_en   = cmd.step_move | cmd.step_emit;
  assign wr_en   = mv_vld_r | cmd.put;
  assign wr_addr = cmd.put ? at_r : mv_addr_r;
  assign wr_data = cmd.put ? val_r : rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r     <= '0;
      mv_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      occ_r     <= occ_nxt;
      mv_vld_r  <= cmd.step_move;
      out_vld_r <= cmd.step_emit | cmd.resp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req_t'(in_req_type);
      val_r <= val_c;
      pos_r <= in_position;
    end
    if (cmd.setup) begin
      at_r   <= at_c[ADDR_W-1:0];
      ptr_r  <= ptr_start;
      stop_r <= ptr_stop;
    end else if (rd_en) begin
      ptr_r <= dir_up ? (ptr_r + ADDR_W'(1)) : (ptr_r - ADDR_W'(1));
    end
    if (cmd.step_move) begin
      mv_addr_r <= dir_up ? (ptr_r - ADDR_W'(1)) : (ptr_r + ADDR_W'(1));
    end
    if (cmd.step_emit) begin
      out_status_r <= ST_OK;
      out_count_r  <= occ_r;
      out_last_r   <= stat.ptr_last;
      out_rd_r     <= 1'b1;
    end else if (cmd.resp) begin
      out_status_r <= cmd.resp_status;
      out_count_r  <= occ_nxt;
      out_last_r   <= 1'b1;
      out_rd_r     <= 1'b0;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_status     = out_status_r;
  assign out_elem_value = out_rd_r ? rd_ext : '0;
  assign out_count      = out_count_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

/* rtl/core/bounded_ordered_list_engine_core.sv */
// Insert at p of n elements: check, shift of elements n-1 down to p, drain, write (check
// then write when p equals n). Delete: check, shift of p+1 up to n-1, count update (no
// shift at the back). Read of n elements: check, then one result a cycle. busy drops as
// the last result shows, so the next transaction may be accepted then. Shift and read run
// through one memory port. rst_n (synchronous) empties the list; contents stay undefined,
// no clearing pass. Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none

module bounded_ordered_list_engine_core #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [bole_pkg::REQ_W-1:0]         in_req_type,
  input  wire logic signed [bole_pkg::VAL_W-1:0]  in_value,
  input  wire logic [bole_pkg::POS_W-1:0]         in_position,
  output logic                                    out_valid,
  output logic [bole_pkg::STAT_W-1:0]             out_status,
  output logic signed [bole_pkg::VAL_W-1:0]       out_elem_value,
  output logic [$clog2(CAPACITY+1)-1:0]           out_count,
  output logic                                    out_last
);

  import bole_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bole_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  bole_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_req_type    (in_req_type),
    .in_value       (in_value),
    .in_position    (in_position),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_elem_value (out_elem_value),
    .out_count      (out_count),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

/* bench/tb_bounded_ordered_list_engine_core.sv */
`timescale 1ns / 100ps

module tb_bounded_ordered_list_engine_core;
  import bole_pkg::*;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int QUIET_TAIL = 70;

  typedef struct {
    status_t                 status;
    logic signed [VAL_W-1:0] elem_value;
    logic [CNT_W-1:0]        count;
    logic                    last;
  } list_resp_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [REQ_W-1:0]        in_req_type;
  logic signed [VAL_W-1:0] in_value;
  logic [POS_W-1:0]        in_position;
  logic                    out_valid;
  logic [STAT_W-1:0]       out_status;
  logic signed [VAL_W-1:0] out_elem_value;
  logic [CNT_W-1:0]        out_count;
  logic                    out_last;

  list_resp_t              list_resp_q[$];
  logic signed [VAL_W-1:0] list_mem[CAPACITY];
  int unsigned             list_len;
  int unsigned             err_cnt;
  int unsigned             txn_cnt;
  int unsigned             resp_cnt;
  int unsigned             stat_hits[4];
  bit                      idle_en;

  bounded_ordered_list_engine_core #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(VAL_W)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_value      (in_value),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_elem_value(out_elem_value),
    .out_count     (out_count),
    .out_last      (out_last)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic signed [VAL_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(VAL_W-1){1'b0}}};
      1: return {1'b0, {(VAL_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_resp(status_t st, logic signed [VAL_W-1:0] ev, logic fin);
    list_resp_t r;
    r.status     = st;
    r.elem_value = ev;
    r.count      = CNT_W'(list_len);
    r.last       = fin;
    list_resp_q.push_back(r);
  endtask

  task automatic apply_request(req_t rq, logic signed [VAL_W-1:0] v, logic [POS_W-1:0] p);
    int unsigned at;
    int unsigned i;
    status_t     st;
    st = ST_OK;
    case (rq)
      REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT: begin
        at = (rq == REQ_INS_FRONT) ? 0 : (rq == REQ_INS_BACK) ? list_len : p;
        if (list_len >= CAPACITY) begin
          st = ST_FULL;
        end else if (at > list_len) begin
          st = ST_BAD_POS;
        end else begin
          for (i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
          list_mem[at] = v;
          list_len++;
        end
        push_resp(st, '0, 1'b1);
      end
      REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT: begin
        if (list_len == 0) begin
          st = ST_EMPTY;
        end else begin
          at = (rq == REQ_DEL_FRONT) ? 0 : (rq == REQ_DEL_BACK) ? list_len - 1 : p;
          if (at >= list_len) begin
            st = ST_BAD_POS;
          end else begin
            for (i = at; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
            list_len--;
          end
        end
        push_resp(st, '0, 1'b1);
      end
      default: begin
        if (list_len == 0) begin
          st = ST_EMPTY;
          push_resp(st, '0, 1'b1);
        end else begin
          for (i = 0; i < list_len; i++) begin
            at = (rq == REQ_RD_FWD) ? i : list_len - 1 - i;
            push_resp(ST_OK, list_mem[at], i + 1 == list_len);
          end
        end
      end
    endcase
    stat_hits[int'(st)]++;
  endtask

  task automatic send_request(req_t rq, logic signed [VAL_W-1:0] v, logic [POS_W-1:0] p);
    int gap;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap   = $urandom_range(1, 3);
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start       = 1'b1;
    in_req_type = rq;
    in_value    = v;
    in_position = p;
    do @(posedge clk); while (busy);
    apply_request(rq, v, p);
    txn_cnt++;
  endtask

  always @(posedge clk) begin
    list_resp_t exp_r;
    if (rst_n && out_valid) begin
      resp_cnt++;
      if (list_resp_q.size() == 0) begin
        $error("unexpected result: status %0d value %0d count %0d last %0d",
               out_status, out_elem_value, out_count, out_last);
        err_cnt++;
      end else begin
        exp_r = list_resp_q.pop_front();
        if (out_status !== exp_r.status) begin
          $error("status mismatch: expected %0d, actual %0d", exp_r.status, out_status);
          err_cnt++;
        end
        if (out_elem_value !== exp_r.elem_value) begin
          $error("elem_value mismatch: expected %0d, actual %0d",
                 exp_r.elem_value, out_elem_value);
          err_cnt++;
        end
        if (out_count !== exp_r.count) begin
          $error("count mismatch: expected %0d, actual %0d", exp_r.count, out_count);
          err_cnt++;
        end
        if (out_last !== exp_r.last) begin
          $error("last mismatch: expected %0d, actual %0d", exp_r.last, out_last);
          err_cnt++;
        end
      end
    end
  end

  task automatic test_empty_list();
    send_request(REQ_RD_FWD, rand_word(), '0);
    send_request(REQ_RD_BACK, rand_word(), '0);
    send_request(REQ_DEL_FRONT, rand_word(), '0);
    send_request(REQ_DEL_BACK, rand_word(), '0);
    send_request(REQ_DEL_AT, rand_word(), 4'd15);
    send_request(REQ_INS_AT, rand_word(), 4'd1);
  endtask

  task automatic test_position_edges();
    send_request(REQ_INS_AT, {1'b1, {(VAL_W-1){1'b0}}}, 4'd0);
    send_request(REQ_DEL_AT, '0, 4'd1);
    send_request(REQ_INS_AT, {1'b0, {(VAL_W-1){1'b1}}}, 4'd1);
    send_request(REQ_DEL_AT, '0, 4'd0);
  endtask

  task automatic test_fill_to_capacity();
    int k;
    k = 0;
    while (list_len < CAPACITY) begin
      case (k % 3)
        0: send_request(REQ_INS_FRONT, rand_word(), '0);
        1: send_request(REQ_INS_BACK, rand_word(), '0);
        default: send_request(REQ_INS_AT, rand_word(),
                              POS_W'((k % 2) ? list_len : $urandom_range(0, list_len)));
      endcase
      k++;
    end
    send_request(REQ_INS_FRONT, rand_word(), '0);
    send_request(REQ_INS_BACK, rand_word(), '0);
    send_request(REQ_INS_AT, rand_word(), 4'd15);
    send_request(REQ_RD_FWD, '0, '0);
    send_request(REQ_RD_BACK, '0, '0);
  endtask

  task automatic test_random_traffic(int n_items);
    bit          growing;
    int          pick;
    int          ins_lim;
    int unsigned hi;
    req_t        rq;
    logic [POS_W-1:0] p;
    growing = 1'b0;
    for (int k = 0; k < n_items; k++) begin
      idle_en = (k < n_items - QUIET_TAIL);
      if (list_len == CAPACITY) growing = 1'b0;
      if (list_len == 0) growing = 1'b1;
      ins_lim = growing ? 72 : 44;
      pick    = $urandom_range(0, 99);
      if (pick < 14) begin
        rq = $urandom_range(0, 1) ? REQ_RD_FWD : REQ_RD_BACK;
      end else if (pick < ins_lim) begin
        case ($urandom_range(0, 2))
          0: rq = REQ_INS_FRONT;
          1: rq = REQ_INS_BACK;
          default: rq = REQ_INS_AT;
        endcase
      end else if (pick < 96) begin
        case ($urandom_range(0, 2))
          0: rq = REQ_DEL_FRONT;
          1: rq = REQ_DEL_BACK;
          default: rq = REQ_DEL_AT;
        endcase
      end else begin
        rq = req_t'($urandom_range(0, 7));
      end
      hi = (list_len > 15) ? 15 : list_len;
      if ($urandom_range(0, 4) == 0) p = POS_W'($urandom_range(0, 15));
      else p = POS_W'($urandom_range(0, hi));
      send_request(rq, rand_word(), p);
    end
  endtask

  initial begin
    int waited;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req_type = REQ_INS_FRONT;
    in_value    = '0;
    in_position = '0;
    list_len    = 0;
    err_cnt     = 0;
    txn_cnt     = 0;
    resp_cnt    = 0;
    idle_en     = 1'b1;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_empty_list();
    test_position_edges();
    test_fill_to_capacity();
    test_random_traffic(440);

    @(negedge clk);
    start = 1'b0;
    waited = 0;
    while (list_resp_q.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (24) @(posedge clk);
    if (list_resp_q.size() != 0) begin
      $error("%0d expected results never arrived", list_resp_q.size());
      err_cnt++;
    end

    $display("summary: %0d transactions, %0d results checked, %0d mismatches",
             txn_cnt, resp_cnt, err_cnt);
    $display("summary: status ok %0d, bad position %0d, empty %0d, full %0d",
             stat_hits[ST_OK], stat_hits[ST_BAD_POS], stat_hits[ST_EMPTY], stat_hits[ST_FULL]);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
rtl/core/bole_pkg.sv
rtl/core/bole_ctrl.sv
rtl/core/bole_dp.sv
rtl/core/bounded_ordered_list_engine_core.sv
bench/tb_bounded_ordered_list_engine_core.sv
